/* rtl/dst_pkg.sv */
// shared types and constants for the seven-point 3d stencil
package dst_pkg;

    localparam int MAX_ROW   = 64;
    localparam int GRID_ROWS = 64;
    localparam int SAMPLE_W  = 32;
    localparam int FRAC_W    = SAMPLE_W - 2;
    localparam int COL_W     = $clog2(MAX_ROW);
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int LEN_W     = COL_W + 1;
    localparam int ADDR_W    = 1 + ROW_W + COL_W;
    localparam int PEND_W    = LEN_W + ROW_W;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int IDX_W     = 4;

    localparam logic [IDX_W-1:0] REG_ROW_LENGTH  = 4'd0;
    localparam logic [IDX_W-1:0] REG_COEF_CENTRE = 4'd1;
    localparam logic [IDX_W-1:0] REG_COEF_EAST   = 4'd2;
    localparam logic [IDX_W-1:0] REG_COEF_WEST   = 4'd3;
    localparam logic [IDX_W-1:0] REG_COEF_NORTH  = 4'd4;
    localparam logic [IDX_W-1:0] REG_COEF_SOUTH  = 4'd5;
    localparam logic [IDX_W-1:0] REG_COEF_TOP    = 4'd6;
    localparam logic [IDX_W-1:0] REG_COEF_BOTTOM = 4'd7;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    typedef struct packed {
        sample_t centre;
        sample_t east;
        sample_t west;
        sample_t north;
        sample_t south;
        sample_t top;
        sample_t bottom;
    } coef_t;

    // neighbour selection for one output point
    typedef struct packed {
        logic    east_ok;
        logic    west_ok;
        logic    north_ok;
        logic    south_ok;
        logic    top_ok;
        logic    bottom_ok;
        logic    last;
        sample_t top;
    } sel_t;

endpackage

/* rtl/diffusion_stencil_3d_7pt_top.sv */
// top level of the seven-point 3d diffusion stencil
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------
//  in      | in_valid / in_stall  | operation, sample
//  out     | out_valid / out_stall| value, saturated, grid_last
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one item per cycle unless in_stall holds it; a result passes these registers in order:
// plane store read, multiply, two adder levels, final add and saturate
// the centre and five neighbour reads use three copies of the plane store, two reads each;
// the top neighbour is the incoming sample. reset clears positions and counts; the plane store is not cleared
// out_stall holds the pipeline stage by stage, empty stages still fill
module diffusion_stencil_3d_7pt_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  dst_pkg::sample_t                    sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output dst_pkg::sample_t                    value,
    output logic                                saturated,
    output logic                                grid_last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dst_pkg::IDX_W-1:0]           cfg_index,
    input  logic [dst_pkg::SAMPLE_W-1:0]        cfg_data
);

    import dst_pkg::*;

    logic [LEN_W-1:0]  len_reg;
    coef_t             coef_reg;
    logic [COL_W-1:0]  in_col_reg, out_col_reg;
    logic [ROW_W-1:0]  in_row_reg, out_row_reg;
    logic              in_plane_reg, out_plane_reg, out_first_reg;
    logic [PEND_W-1:0] pending_reg;
    logic              s1_valid_reg;
    sel_t              s1_sel_reg;

    logic              accept, push, produce_push, produce, is_last;
    logic              calc_ready, cfg_wr;
    logic [PEND_W-1:0] plane_size;
    logic [LEN_W-1:0]  len_clamped;
    logic [ADDR_W-1:0] wr_addr, a_centre, a_east, a_west, a_north, a_south, a_bottom;
    sample_t           d_centre, d_east, d_west, d_north, d_south, d_bottom;
    logic              in_col_wrap, out_col_wrap;

    assign cfg_ready  = 1'b1;
    assign cfg_wr     = cfg_valid && cfg_ready;
    assign in_stall   = s1_valid_reg && !calc_ready;
    assign accept     = in_valid && !in_stall;
    assign push       = (operation == OP_PUSH);
    assign plane_size = {len_reg, {ROW_W{1'b0}}};
    assign produce_push = (pending_reg >= plane_size);
    assign produce    = push ? produce_push : (pending_reg != '0);
    assign is_last    = !push && (pending_reg == PEND_W'(1));

    assign in_col_wrap  = (LEN_W'(in_col_reg) + LEN_W'(1)) >= len_reg;
    assign out_col_wrap = (LEN_W'(out_col_reg) + LEN_W'(1)) >= len_reg;

    always_comb
    begin
        if (cfg_data[SAMPLE_W-1:LEN_W] != '0 || cfg_data[LEN_W-1:0] > LEN_W'(MAX_ROW))
        begin
            len_clamped = LEN_W'(MAX_ROW);
        end
        else if (cfg_data[LEN_W-1:0] < LEN_W'(2))
        begin
            len_clamped = LEN_W'(2);
        end
        else
        begin
            len_clamped = cfg_data[LEN_W-1:0];
        end
    end

    assign wr_addr  = {in_plane_reg, in_row_reg, in_col_reg};
    assign a_centre = {out_plane_reg, out_row_reg, out_col_reg};
    assign a_east   = {out_plane_reg, out_row_reg, out_col_reg + COL_W'(1)};
    assign a_west   = {out_plane_reg, out_row_reg, out_col_reg - COL_W'(1)};
    assign a_north  = {out_plane_reg, out_row_reg - ROW_W'(1), out_col_reg};
    assign a_south  = {out_plane_reg, out_row_reg + ROW_W'(1), out_col_reg};
    assign a_bottom = {~out_plane_reg, out_row_reg, out_col_reg};

    dst_ram #(.ADDR_W(ADDR_W), .DATA_W(SAMPLE_W)) u_ram_a (
        .clk       (clk),
        .wr_en     (accept && push),
        .wr_addr   (wr_addr),
        .wr_data   (sample),
        .rd_en     (accept),
        .rd_addr_a (a_centre),
        .rd_addr_b (a_east),
        .rd_data_a (d_centre),
        .rd_data_b (d_east)
    );

    dst_ram #(.ADDR_W(ADDR_W), .DATA_W(SAMPLE_W)) u_ram_b (
        .clk       (clk),
        .wr_en     (accept && push),
        .wr_addr   (wr_addr),
        .wr_data   (sample),
        .rd_en     (accept),
        .rd_addr_a (a_west),
        .rd_addr_b (a_north),
        .rd_data_a (d_west),
        .rd_data_b (d_north)
    );

    dst_ram #(.ADDR_W(ADDR_W), .DATA_W(SAMPLE_W)) u_ram_c (
        .clk       (clk),
        .wr_en     (accept && push),
        .wr_addr   (wr_addr),
        .wr_data   (sample),
        .rd_en     (accept),
        .rd_addr_a (a_south),
        .rd_addr_b (a_bottom),
        .rd_data_a (d_south),
        .rd_data_b (d_bottom)
    );

    dst_calc u_calc (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid_reg),
        .s1_sel     (s1_sel_reg),
        .centre     (d_centre),
        .east       (d_east),
        .west       (d_west),
        .north      (d_north),
        .south      (d_south),
        .bottom     (d_bottom),
        .coef       (coef_reg),
        .take_ready (calc_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .saturated  (saturated),
        .grid_last  (grid_last)
    );

    // selection flags travel beside the registered read data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sel_reg.east_ok   <= !out_col_wrap;
            s1_sel_reg.west_ok   <= (out_col_reg != '0);
            s1_sel_reg.north_ok  <= (out_row_reg != '0);
            s1_sel_reg.south_ok  <= (out_row_reg != ROW_W'(GRID_ROWS - 1));
            s1_sel_reg.top_ok    <= push;
            s1_sel_reg.bottom_ok <= !out_first_reg;
            s1_sel_reg.last      <= is_last;
            s1_sel_reg.top       <= sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= LEN_W'(MAX_ROW);
            coef_reg      <= '0;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_plane_reg  <= 1'b0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_plane_reg <= 1'b0;
            out_first_reg <= 1'b1;
            pending_reg   <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= produce;
            end
            else if (calc_ready)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (cfg_wr)
            begin
                case (cfg_index)
                    REG_ROW_LENGTH:
                    begin
                        len_reg       <= len_clamped;
                        in_col_reg    <= '0;
                        in_row_reg    <= '0;
                        in_plane_reg  <= 1'b0;
                        out_col_reg   <= '0;
                        out_row_reg   <= '0;
                        out_plane_reg <= 1'b0;
                        out_first_reg <= 1'b1;
                        pending_reg   <= '0;
                    end
                    REG_COEF_CENTRE: coef_reg.centre <= cfg_data;
                    REG_COEF_EAST:   coef_reg.east   <= cfg_data;
                    REG_COEF_WEST:   coef_reg.west   <= cfg_data;
                    REG_COEF_NORTH:  coef_reg.north  <= cfg_data;
                    REG_COEF_SOUTH:  coef_reg.south  <= cfg_data;
                    REG_COEF_TOP:    coef_reg.top    <= cfg_data;
                    REG_COEF_BOTTOM: coef_reg.bottom <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            else if (accept)
            begin
                if (push)
                begin
                    if (!produce_push)
                    begin
                        pending_reg <= pending_reg + PEND_W'(1);
                    end
                    if (in_col_wrap)
                    begin
                        in_col_reg <= '0;
                        if (in_row_reg == ROW_W'(GRID_ROWS - 1))
                        begin
                            in_row_reg   <= '0;
                            in_plane_reg <= ~in_plane_reg;
                        end
                        else
                        begin
                            in_row_reg <= in_row_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        in_col_reg <= in_col_reg + COL_W'(1);
                    end
                end
                else if (produce)
                begin
                    pending_reg <= pending_reg - PEND_W'(1);
                end

                // the last drain puts the stream back to its start
                if (is_last)
                begin
                    in_col_reg    <= '0;
                    in_row_reg    <= '0;
                    in_plane_reg  <= 1'b0;
                    out_col_reg   <= '0;
                    out_row_reg   <= '0;
                    out_plane_reg <= 1'b0;
                    out_first_reg <= 1'b1;
                end
                else if (produce)
                begin
                    if (out_col_wrap)
                    begin
                        out_col_reg <= '0;
                        if (out_row_reg == ROW_W'(GRID_ROWS - 1))
                        begin
                            out_row_reg   <= '0;
                            out_plane_reg <= ~out_plane_reg;
                            out_first_reg <= 1'b0;
                        end
                        else
                        begin
                            out_row_reg <= out_row_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + COL_W'(1);
                    end
                end
            end
        end
    end

endmodule

/* rtl/dst_ram.sv */
// plane store ram: one write port, two registered read ports
module dst_ram #(
    parameter int ADDR_W = 13,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // reads return the old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

/* rtl/dst_calc.sv */
// multiply, sum, round and saturate pipeline of the stencil
module dst_calc (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s1_valid,
    input  dst_pkg::sel_t    s1_sel,
    input  dst_pkg::sample_t centre,
    input  dst_pkg::sample_t east,
    input  dst_pkg::sample_t west,
    input  dst_pkg::sample_t north,
    input  dst_pkg::sample_t south,
    input  dst_pkg::sample_t bottom,
    input  dst_pkg::coef_t   coef,
    output logic             take_ready,
    output logic             out_valid,
    input  logic             out_stall,
    output dst_pkg::sample_t value,
    output logic             saturated,
    output logic             grid_last
);

    import dst_pkg::*;

    sample_t nb [7];
    sample_t cf [7];
    prod_t   prod_reg [7];
    acc_t    sum4_reg [4];
    acc_t    sum2_reg [2];
    acc_t    total;
    logic    last2_reg, last3_reg, last4_reg;
    logic    v2_reg, v3_reg, v4_reg, vo_reg;
    logic    rdy_o, rdy4, rdy3, rdy2;
    logic    fits;

    assign rdy_o      = !vo_reg || !out_stall;
    assign rdy4       = !v4_reg || rdy_o;
    assign rdy3       = !v3_reg || rdy4;
    assign rdy2       = !v2_reg || rdy3;
    assign take_ready = rdy2;
    assign out_valid  = vo_reg;

    // missing neighbours fall back to the centre value
    always_comb
    begin
        nb[0] = centre;
        nb[1] = s1_sel.east_ok   ? east       : centre;
        nb[2] = s1_sel.west_ok   ? west       : centre;
        nb[3] = s1_sel.north_ok  ? north      : centre;
        nb[4] = s1_sel.south_ok  ? south      : centre;
        nb[5] = s1_sel.top_ok    ? s1_sel.top : centre;
        nb[6] = s1_sel.bottom_ok ? bottom     : centre;
        cf[0] = coef.centre;
        cf[1] = coef.east;
        cf[2] = coef.west;
        cf[3] = coef.north;
        cf[4] = coef.south;
        cf[5] = coef.top;
        cf[6] = coef.bottom;
    end

    // final add; the half added in the first adder level makes the cut round to nearest, ties up
    assign total = sum2_reg[0] + sum2_reg[1];
    assign fits  = (total[ACC_W-1:FRAC_W+SAMPLE_W-1] == '0) ||
                   (total[ACC_W-1:FRAC_W+SAMPLE_W-1] == '1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy2)
            begin
                v2_reg <= s1_valid;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy_o)
            begin
                vo_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && s1_valid)
        begin
            for (int i = 0; i < 7; i++)
            begin
                prod_reg[i] <= prod_t'(nb[i]) * prod_t'(cf[i]);
            end
            last2_reg <= s1_sel.last;
        end
        if (rdy3 && v2_reg)
        begin
            sum4_reg[0] <= acc_t'(prod_reg[0]) + acc_t'(prod_reg[1]);
            sum4_reg[1] <= acc_t'(prod_reg[2]) + acc_t'(prod_reg[3]);
            sum4_reg[2] <= acc_t'(prod_reg[4]) + acc_t'(prod_reg[5]);
            sum4_reg[3] <= acc_t'(prod_reg[6]) + (acc_t'(1) <<< (FRAC_W - 1));
            last3_reg   <= last2_reg;
        end
        if (rdy4 && v3_reg)
        begin
            sum2_reg[0] <= sum4_reg[0] + sum4_reg[1];
            sum2_reg[1] <= sum4_reg[2] + sum4_reg[3];
            last4_reg   <= last3_reg;
        end
        if (rdy_o && v4_reg)
        begin
            if (fits)
            begin
                value <= total[FRAC_W+SAMPLE_W-1:FRAC_W];
            end
            else if (total[ACC_W-1])
            begin
                value <= {1'b1, {(SAMPLE_W-1){1'b0}}};
            end
            else
            begin
                value <= {1'b0, {(SAMPLE_W-1){1'b1}}};
            end
            saturated <= !fits;
            grid_last <= last4_reg;
        end
    end

endmodule

/* tb/diffusion_stencil_3d_7pt_top_tb.sv */
// testbench for the seven-point 3d diffusion stencil top level
`timescale 1ns / 1ps

module diffusion_stencil_3d_7pt_top_tb;
    import dst_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int PLANE_SLOTS = MAX_ROW * GRID_ROWS;

    // register indexes that map to nothing
    localparam logic [IDX_W-1:0] REG_UNMAPPED_MID = 4'd9;
    localparam logic [IDX_W-1:0] REG_UNMAPPED_TOP = 4'd15;

    typedef struct {
        sample_t value;
        logic    saturated;
        logic    grid_last;
    } point_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic             operation;
    sample_t          sample;
    logic             out_valid;
    logic             out_stall;
    sample_t          value;
    logic             saturated;
    logic             grid_last;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [SAMPLE_W-1:0] cfg_data;

    // predictor state
    sample_t plane_mem [0:2*PLANE_SLOTS-1];
    sample_t weights [0:6];
    int      in_col, in_row, in_plane;
    int      out_col, out_row, out_plane;
    int      out_first;
    int      pending;
    int      row_len;

    point_t  expected_points[$];
    int      errors;
    int      items_sent;
    int      quiet_cycles = 0;
    bit      steady_in;
    bit      steady_out;

    diffusion_stencil_3d_7pt_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .saturated (saturated),
        .grid_last (grid_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int slot_of(int pl, int r, int c);
        return (pl * PLANE_SLOTS + r * MAX_ROW + c) % (2 * PLANE_SLOTS);
    endfunction

    function automatic void restart_stream();
        in_col = 0; in_row = 0; in_plane = 0;
        out_col = 0; out_row = 0; out_plane = 0;
        out_first = 1;
        pending = 0;
    endfunction

    // weighted sum at the output position, rounded and saturated
    function automatic point_t stencil_point(bit top_ok, sample_t top);
        sample_t nb [0:6];
        sample_t c;
        logic signed [79:0] acc;
        logic signed [79:0] shifted;
        longint prod;
        point_t p;
        c = plane_mem[slot_of(out_plane, out_row, out_col)];
        nb[0] = c;
        nb[1] = (out_col + 1 < row_len) ? plane_mem[slot_of(out_plane, out_row, out_col + 1)] : c;
        nb[2] = (out_col > 0) ? plane_mem[slot_of(out_plane, out_row, out_col - 1)] : c;
        nb[3] = (out_row > 0) ? plane_mem[slot_of(out_plane, out_row - 1, out_col)] : c;
        nb[4] = (out_row + 1 < GRID_ROWS) ?
                plane_mem[slot_of(out_plane, out_row + 1, out_col)] : c;
        nb[5] = top_ok ? top : c;
        nb[6] = out_first ? c : plane_mem[slot_of(out_plane ^ 1, out_row, out_col)];
        acc = '0;
        for (int i = 0; i < 7; i++)
        begin
            prod = longint'(weights[i]) * longint'(nb[i]);
            acc += prod;
        end
        acc += 80'sd1 <<< (FRAC_W - 1);
        shifted = acc >>> FRAC_W;
        if (shifted > 80'sh7FFF_FFFF)
        begin
            p.value = 32'sh7FFF_FFFF;
            p.saturated = 1'b1;
        end
        else if (shifted < -80'sh8000_0000)
        begin
            p.value = 32'sh8000_0000;
            p.saturated = 1'b1;
        end
        else
        begin
            p.value = shifted[31:0];
            p.saturated = 1'b0;
        end
        p.grid_last = 1'b0;
        return p;
    endfunction

    function automatic void advance_out();
        out_col++;
        if (out_col >= row_len)
        begin
            out_col = 0;
            out_row++;
            if (out_row >= GRID_ROWS)
            begin
                out_row = 0;
                out_plane ^= 1;
                out_first = 0;
            end
        end
    endfunction

    function automatic void predict_item(logic op, sample_t smp);
        point_t p;
        if (op == OP_PUSH)
        begin
            if (pending >= row_len * GRID_ROWS)
            begin
                p = stencil_point(1'b1, smp);
                expected_points.push_back(p);
                advance_out();
            end
            else
                pending++;
            plane_mem[slot_of(in_plane, in_row, in_col)] = smp;
            in_col++;
            if (in_col >= row_len)
            begin
                in_col = 0;
                in_row++;
                if (in_row >= GRID_ROWS)
                begin
                    in_row = 0;
                    in_plane ^= 1;
                end
            end
        end
        else if (pending > 0)
        begin
            p = stencil_point(1'b0, '0);
            advance_out();
            pending--;
            p.grid_last = (pending == 0);
            expected_points.push_back(p);
            if (pending == 0)
                restart_stream();
        end
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic send_item(input logic op, input sample_t smp);
        int gap;
        gap = steady_in ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        operation <= op;
        sample    <= smp;
        do @(posedge clk); while (in_stall);
        predict_item(op, smp);
        items_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (expected_points.size() == 0);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_ROW_LENGTH)
        begin
            row_len = (data < 2) ? 2 : (data > MAX_ROW) ? MAX_ROW : int'(data);
            restart_stream();
        end
        else if (idx <= REG_COEF_BOTTOM)
            weights[idx - 1] = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic sample_t rand_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic set_weights(input bit extreme);
        for (int i = 0; i < 7; i++)
            write_reg(REG_COEF_CENTRE + IDX_W'(i),
                      extreme ? ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                              : rand_value());
    endtask

    task automatic push_points(input int n);
        for (int i = 0; i < n; i++)
            send_item(OP_PUSH, rand_value());
    endtask

    task automatic drain_all();
        while (pending > 0)
            send_item(OP_DRAIN, $urandom);
    endtask

    // whole-plane grid: pushes then drains
    task automatic run_grid(input int planes);
        push_points(planes * row_len * GRID_ROWS);
        drain_all();
    endtask

    task automatic test_register_limits();
        write_reg(REG_ROW_LENGTH, 32'd0);
        write_reg(REG_UNMAPPED_MID, $urandom);
        write_reg(REG_UNMAPPED_TOP, $urandom);
        write_reg(REG_ROW_LENGTH, 32'd127);
        write_reg(REG_ROW_LENGTH, 32'd1);
    endtask

    task automatic test_saturation();
        // drain with nothing pending gives nothing
        send_item(OP_DRAIN, '0);
        send_item(OP_DRAIN, '1);
        for (int i = 0; i < 7; i++)
            write_reg(REG_COEF_CENTRE + IDX_W'(i), 32'h7FFF_FFFF);
        for (int i = 0; i < 2 * row_len * GRID_ROWS; i++)
            send_item(OP_PUSH, (i % 5 < 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000);
        drain_all();
    endtask

    task automatic test_random_grids();
        int start;
        start = items_sent;
        while (items_sent - start < 200)
        begin
            steady_in  = ($urandom_range(0, 4) == 0);
            steady_out = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 1))
                write_reg(REG_ROW_LENGTH, $urandom_range(2, 3));
            set_weights($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 3) == 0)
                send_item(OP_DRAIN, $urandom);
            run_grid($urandom_range(1, 2));
        end
        steady_in  = 1'b0;
        steady_out = 1'b0;
    endtask

    // both planes of the two-point rows were filled by the saturation test,
    // so every later read is of written data
    task automatic test_broken_sequences();
        write_reg(REG_ROW_LENGTH, 32'd2);
        set_weights(1'b0);
        push_points(row_len * GRID_ROWS + $urandom_range(1, 100));
        drain_all();
        push_points(row_len * GRID_ROWS + 5);
        for (int i = 0; i < 10; i++)
            send_item(OP_DRAIN, $urandom);
        push_points(7);
        drain_all();
        write_reg(REG_ROW_LENGTH, 32'd3);
    endtask

    // output side stall, one draw per item
    initial
    begin
        int n;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            n = steady_out ? 0 : $urandom_range(0, 13);
            if (n > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    always @(posedge clk)
    begin
        point_t p;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_points.size() == 0)
                report("unexpected item", value, '0);
            else
            begin
                p = expected_points.pop_front();
                if (value !== p.value)
                    report("value", value, p.value);
                if (saturated !== p.saturated)
                    report("saturated", 32'(saturated), 32'(p.saturated));
                if (grid_last !== p.grid_last)
                    report("grid_last", 32'(grid_last), 32'(p.grid_last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_PUSH;
        sample = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        items_sent = 0;
        steady_in = 1'b0;
        steady_out = 1'b0;
        for (int i = 0; i < 7; i++)
            weights[i] = '0;
        for (int i = 0; i < 2 * PLANE_SLOTS; i++)
            plane_mem[i] = '0;
        row_len = MAX_ROW;
        restart_stream();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_limits();
        test_saturation();
        test_random_grids();
        test_broken_sequences();

        settle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dst_pkg.sv
rtl/dst_ram.sv
rtl/dst_calc.sv
rtl/diffusion_stencil_3d_7pt_top.sv
tb/diffusion_stencil_3d_7pt_top_tb.sv
